@@ hw/rtl/dpsh_pkg.sv @@
// Package for the dual polynomial substring hash block.
// Holds widths, reset values, action/status codes, register indices and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
package dpsh_pkg;
    localparam int W_VAL = 31;
    localparam int W_LEN = 13;
    localparam int MAX_LEN_DEF = 4096;
    localparam logic [W_VAL-1:0] RST_BASE_A = 31'd131;
    localparam logic [W_VAL-1:0] RST_MOD_A  = 31'd1000000007;
    localparam logic [W_VAL-1:0] RST_BASE_B = 31'd137;
    localparam logic [W_VAL-1:0] RST_MOD_B  = 31'd998244353;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] REG_BASE_A = 2'd0;
    localparam logic [1:0] REG_MOD_A  = 2'd1;
    localparam logic [1:0] REG_BASE_B = 2'd2;
    localparam logic [1:0] REG_MOD_B  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_LD, S_REDUCE, S_MUL, S_MULRED, S_FIN, S_SUB, S_DONE
    } t_state;
endpackage

@@ hw/rtl/dpsh_mulmod.sv @@
// Bit-serial modular multiplier: x*y mod m, one multiplier bit per cycle.
// Depends on dpsh_pkg. i_x must be below m; i_y may take any 32-bit value.
`timescale 1ns / 1ps
module dpsh_mulmod
    import dpsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [W_VAL:0]    i_x,
    input  logic [W_VAL:0]    i_y,
    input  logic [W_VAL:0]    i_m,
    output logic              o_done,
    output logic [W_VAL:0]    o_p
);
    logic [W_VAL:0] r_acc, r_x, r_y, r_m;
    logic [5:0]     r_cnt;
    logic           r_busy;
    logic [W_VAL+1:0] dbl, d1, add, a1;

    // double accumulator then add x if the current top bit is set, both mod m
    always_comb begin
        dbl = {r_acc, 1'b0};
        d1  = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        add = d1 + (r_y[W_VAL] ? {1'b0, r_x} : '0);
        a1  = (add >= {1'b0, r_m}) ? add - {1'b0, r_m} : add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_acc  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_m    <= i_m;
            end else if (r_busy) begin
                r_acc <= a1[W_VAL:0];
                r_y   <= {r_y[W_VAL-1:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(W_VAL)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_p = r_acc;
endmodule

@@ hw/rtl/dual_polynomial_substring_hash_top.sv @@
// Dual polynomial substring hash, two lanes, bit-serial modular multiply.
// Clear, an unused action, an empty range or an error skip the reduction and the multiplies.
// One item at a time, busy high through the strobe; the next item can be taken in the cycle after it.
// Each append or query runs 31 serial reduction steps plus one (query) or two (append)
// serial multiplies. Result strobe o_valid lasts one cycle and cannot be stalled.
// Synchronous active-low reset clears length, registers to defaults; tables need no clearing.
`timescale 1ns / 1ps
module dual_polynomial_substring_hash_top
    import dpsh_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [W_VAL-1:0]  i_cfg_data,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_byte_in,
    input  logic [W_LEN-1:0]  i_left,
    input  logic [W_LEN-1:0]  i_right,
    output logic              o_valid,
    output logic [W_VAL-1:0]  o_hash_a,
    output logic [W_VAL-1:0]  o_hash_b,
    output logic [1:0]        o_status,
    output logic [W_LEN-1:0]  o_length
);
    localparam int AW = $clog2(MAX_LEN + 1);

    // configuration registers
    logic [W_VAL-1:0] r_base_a, r_mod_a, r_base_b, r_mod_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_a <= RST_BASE_A; r_mod_a <= RST_MOD_A;
            r_base_b <= RST_BASE_B; r_mod_b <= RST_MOD_B;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BASE_A: r_base_a <= i_cfg_data;
                REG_MOD_A:  r_mod_a  <= i_cfg_data;
                REG_BASE_B: r_base_b <= i_cfg_data;
                REG_MOD_B:  r_mod_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective modulus: zero means 2^31
    logic [W_VAL:0] m_a, m_b;
    assign m_a = (r_mod_a == '0) ? {1'b1, {W_VAL{1'b0}}} : {1'b0, r_mod_a};
    assign m_b = (r_mod_b == '0) ? {1'b1, {W_VAL{1'b0}}} : {1'b0, r_mod_b};

    // tables: prefix and power per lane, entry 0 handled by forcing
    logic [W_VAL-1:0] mem_pa [MAX_LEN+1];
    logic [W_VAL-1:0] mem_pb [MAX_LEN+1];
    logic [W_VAL-1:0] mem_wa [MAX_LEN+1];
    logic [W_VAL-1:0] mem_wb [MAX_LEN+1];

    t_state r_state, n_state;
    logic [AW-1:0]    r_len;
    logic [1:0]       r_act;
    logic [7:0]       r_byte;
    logic [AW-1:0]    r_ia, r_ib;     // empty-range flag, prefix index at right
    logic [W_VAL-1:0] rd_pa, rd_pb, rd_wa, rd_wb; // registered reads
    logic [AW-1:0]    r_qa, r_qb;
    logic [W_VAL:0]   r_h1a, r_h1b, r_h2a, r_h2b, r_pwa, r_pwb; // reduced operands
    logic [W_VAL:0]   r_rm1a, r_rm1b, r_rm2a, r_rm2b; // partial remainders
    logic [W_VAL:0]   r_rba, r_rbb;   // byte remainders per lane
    logic [4:0]       r_rcnt;         // reduction step
    logic [1:0]       r_phase;        // mult pass index
    logic [W_VAL:0]   r_ra0, r_rb0;   // first products
    logic [W_VAL-1:0] r_oa, r_ob;
    logic [1:0]       r_ost;
    logic             mul_start, da, db;
    logic [W_VAL:0]   mx_a, my_a, mx_b, my_b, pa, pb;

    // one restoring step: shift in a bit, subtract m once if reached
    function automatic logic [W_VAL:0] rem_step(input logic [W_VAL:0] rem,
                                                input logic bit_in,
                                                input logic [W_VAL:0] m);
        logic [W_VAL+1:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, m}) t = t - {1'b0, m};
        return t[W_VAL:0];
    endfunction

    // registered table reads; index 0 reads prefix 0 and power 1
    always_ff @(posedge i_clk) begin
        rd_pa <= (r_qa == '0) ? '0 : mem_pa[r_qa];
        rd_pb <= (r_qa == '0) ? '0 : mem_pb[r_qa];
        rd_wa <= (r_qb == '0) ? W_VAL'(1) : mem_wa[r_qb];
        rd_wb <= (r_qb == '0) ? W_VAL'(1) : mem_wb[r_qb];
    end

    dpsh_mulmod u_mul_a (.i_clk, .i_rst_n, .i_start(mul_start), .i_x(mx_a), .i_y(my_a),
                         .i_m(m_a), .o_done(da), .o_p(pa));
    dpsh_mulmod u_mul_b (.i_clk, .i_rst_n, .i_start(mul_start), .i_x(mx_b), .i_y(my_b),
                         .i_m(m_b), .o_done(db), .o_p(pb));

    // reduce the multiplicands and the byte by m, one bit per cycle
    logic [W_VAL:0] ba, bb;
    assign ba = {1'b0, r_base_a};
    assign bb = {1'b0, r_base_b};
    logic red_done;
    assign red_done = (r_rcnt == 5'(W_VAL - 1));
    logic byte_bit;
    assign byte_bit = (r_rcnt >= 5'(W_VAL - 8)) && r_byte[7];

    // operand select per pass: pass0 h*b or hl*p; pass1 p*b
    always_comb begin
        mx_a = r_h1a; mx_b = r_h1b;
        my_a = r_pwa; my_b = r_pwb;
        if (r_phase == 2'd1) begin
            mx_a = r_h2a; mx_b = r_h2b;
        end
    end

    logic [W_LEN:0] qsum;
    assign qsum = {1'b0, i_right} + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_RD;
            S_RD:     n_state = (r_ost != ST_OK || (r_act != ACT_APPEND && r_act != ACT_QUERY)
                                 || (r_act == ACT_QUERY && r_ia == '1))
                                 ? S_DONE : S_RDW;
            S_RDW:    n_state = S_LD;
            S_LD:     n_state = S_REDUCE;
            S_REDUCE: if (red_done) n_state = S_MUL;
            S_MUL:    n_state = S_MULRED;
            S_MULRED: if (da && db)
                          n_state = (r_phase == 2'd0 && r_act == ACT_APPEND) ? S_MUL : S_FIN;
            S_FIN:    n_state = S_DONE;
            S_SUB:    n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs from state
    always_comb begin
        busy      = (r_state != S_IDLE);
        mul_start = (r_state == S_MUL);
        o_valid   = (r_state == S_DONE);
    end
    assign o_hash_a = r_oa;
    assign o_hash_b = r_ob;
    assign o_status = r_ost;
    assign o_length = W_LEN'(r_len);

    logic [W_VAL+1:0] fa, fb;
    always_comb begin
        fa = {1'b0, r_h2a} + {1'b0, m_a} - {1'b0, pa};
        fb = {1'b0, r_h2b} + {1'b0, m_b} - {1'b0, pb};
        if (fa >= {1'b0, m_a}) fa = fa - {1'b0, m_a};
        if (fb >= {1'b0, m_b}) fb = fb - {1'b0, m_b};
    end
    logic [W_VAL+1:0] ea, eb;
    always_comb begin
        ea = {1'b0, r_ra0} + {1'b0, r_rba};
        eb = {1'b0, r_rb0} + {1'b0, r_rbb};
        if (ea >= {1'b0, m_a}) ea = ea - {1'b0, m_a};
        if (eb >= {1'b0, m_b}) eb = eb - {1'b0, m_b};
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_act <= i_action; r_byte <= i_byte_in;
                    r_oa <= '0; r_ob <= '0; r_ost <= ST_OK;
                    r_phase <= '0;
                    r_ia <= '0;
                    if (i_action == ACT_APPEND) begin
                        if (r_len >= AW'(MAX_LEN)) r_ost <= ST_FULL;
                        r_qa <= r_len; r_qb <= r_len;
                    end else if (i_action == ACT_QUERY) begin
                        if (i_left == '0 || {1'b0, i_right} > (W_LEN+1)'(r_len)
                            || {1'b0, i_left} > qsum)
                            r_ost <= ST_BAD;
                        else if ({1'b0, i_left} == qsum) r_ia <= '1;
                        r_qa <= AW'(i_left - 1'b1);
                        r_qb <= AW'(i_right - i_left + 1'b1);
                        r_ib <= AW'(i_right);
                    end else if (i_action == ACT_CLEAR) begin
                        r_len <= '0;
                    end
                end
                S_RD: begin
                    // second read: prefix at right for query
                    if (r_act == ACT_QUERY) r_qa <= r_ib;
                end
                S_RDW: begin
                    r_h1a <= {1'b0, rd_pa}; r_h1b <= {1'b0, rd_pb};
                    r_pwa <= {1'b0, rd_wa}; r_pwb <= {1'b0, rd_wb};
                end
                S_LD: begin
                    if (r_act == ACT_QUERY) begin
                        r_h2a <= {1'b0, rd_pa}; r_h2b <= {1'b0, rd_pb};
                        // append path: h*b then p*b; query: hl*p
                    end else begin
                        r_h2a <= r_pwa; r_h2b <= r_pwb;
                        r_pwa <= ba;    r_pwb <= bb;
                    end
                    r_rcnt <= '0;
                    r_rm1a <= '0; r_rm1b <= '0; r_rm2a <= '0; r_rm2b <= '0;
                    r_rba  <= '0; r_rbb  <= '0;
                end
                S_REDUCE: begin
                    // advance the remainders; the last step writes them back
                    r_rcnt <= r_rcnt + 5'd1;
                    r_rba  <= rem_step(r_rba, byte_bit, m_a);
                    r_rbb  <= rem_step(r_rbb, byte_bit, m_b);
                    if (r_rcnt >= 5'(W_VAL - 8)) r_byte <= {r_byte[6:0], 1'b0};
                    if (red_done) begin
                        r_h1a <= rem_step(r_rm1a, r_h1a[W_VAL-1], m_a);
                        r_h1b <= rem_step(r_rm1b, r_h1b[W_VAL-1], m_b);
                        r_h2a <= rem_step(r_rm2a, r_h2a[W_VAL-1], m_a);
                        r_h2b <= rem_step(r_rm2b, r_h2b[W_VAL-1], m_b);
                    end else begin
                        r_rm1a <= rem_step(r_rm1a, r_h1a[W_VAL-1], m_a);
                        r_rm1b <= rem_step(r_rm1b, r_h1b[W_VAL-1], m_b);
                        r_rm2a <= rem_step(r_rm2a, r_h2a[W_VAL-1], m_a);
                        r_rm2b <= rem_step(r_rm2b, r_h2b[W_VAL-1], m_b);
                        r_h1a  <= {r_h1a[W_VAL-1:0], 1'b0};
                        r_h1b  <= {r_h1b[W_VAL-1:0], 1'b0};
                        r_h2a  <= {r_h2a[W_VAL-1:0], 1'b0};
                        r_h2b  <= {r_h2b[W_VAL-1:0], 1'b0};
                    end
                end
                S_MULRED: if (da && db) begin
                    if (r_phase == 2'd0) begin
                        r_ra0 <= pa; r_rb0 <= pb;
                        if (r_act == ACT_QUERY) r_phase <= 2'd2;
                        else r_phase <= 2'd1;
                    end
                end
                S_FIN: begin
                    if (r_act == ACT_QUERY) begin
                        r_oa <= fa[W_VAL-1:0]; r_ob <= fb[W_VAL-1:0];
                    end else begin
                        mem_pa[r_len + 1'b1] <= ea[W_VAL-1:0];
                        mem_pb[r_len + 1'b1] <= eb[W_VAL-1:0];
                        mem_wa[r_len + 1'b1] <= pa[W_VAL-1:0];
                        mem_wb[r_len + 1'b1] <= pb[W_VAL-1:0];
                        r_len <= r_len + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // a strobe is only raised while busy, one per item
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("strobe without busy");
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double strobe");
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= AW'(MAX_LEN)) else $error("length overflow");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_hash_a == '0 && o_hash_b == '0))
        else $error("hash on error");
endmodule

@@ sim/dual_polynomial_substring_hash_top_tb.sv @@
// Self-checking testbench for the dual polynomial substring hash block.
// A scoreboard class keeps a mirror of both lanes' tables and checks every result beat.
// Depends on dpsh_pkg and dual_polynomial_substring_hash_top.
`timescale 1ns / 1ps

import dpsh_pkg::*;

typedef struct {
    logic [W_VAL-1:0] hash_a;
    logic [W_VAL-1:0] hash_b;
    logic [1:0]       status;
    logic [W_LEN-1:0] length;
} hash_beat_t;

class hash_scoreboard;
    logic [W_VAL-1:0] base_r [2];
    logic [W_VAL-1:0] mod_r  [2];
    logic [W_VAL-1:0] prefix [2][0:MAX_LEN_DEF];
    logic [W_VAL-1:0] power  [2][0:MAX_LEN_DEF];
    int               str_len;
    hash_beat_t       pending [$];
    int               errors;

    function new();
        base_r[0] = RST_BASE_A;
        mod_r[0]  = RST_MOD_A;
        base_r[1] = RST_BASE_B;
        mod_r[1]  = RST_MOD_B;
        for (int k = 0; k < 2; k++) begin
            prefix[k][0] = '0;
            power[k][0]  = W_VAL'(1);
        end
        str_len = 0;
        errors  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [W_VAL-1:0] val);
        case (idx)
            REG_BASE_A: base_r[0] = val;
            REG_MOD_A:  mod_r[0]  = val;
            REG_BASE_B: base_r[1] = val;
            REG_MOD_B:  mod_r[1]  = val;
        endcase
    endfunction

    // A zero modulus register stands for 2^31
    function longint unsigned lane_mod(int k);
        return (mod_r[k] == 0) ? 64'h8000_0000 : 64'(mod_r[k]);
    endfunction

    function logic [W_VAL-1:0] substring_hash(int k, int l, int r);
        longint unsigned m, hr, hl, p, sub;
        m   = lane_mod(k);
        hr  = 64'(prefix[k][r]) % m;
        hl  = 64'(prefix[k][l-1]) % m;
        p   = 64'(power[k][r-l+1]) % m;
        sub = (hl * p) % m;
        return W_VAL'((hr + m - sub) % m);
    endfunction

    // Advance the mirror for one accepted beat and queue its expected result
    function void note_item(logic [1:0] act, logic [7:0] b, logic [W_LEN-1:0] l,
                            logic [W_LEN-1:0] r);
        hash_beat_t e;
        longint unsigned m, bb;
        e = '{default: '0};
        if (act == ACT_APPEND) begin
            if (str_len >= MAX_LEN_DEF) begin
                e.status = ST_FULL;
            end else begin
                for (int k = 0; k < 2; k++) begin
                    m  = lane_mod(k);
                    bb = 64'(base_r[k]) % m;
                    prefix[k][str_len+1] =
                        W_VAL'(((64'(prefix[k][str_len]) % m) * bb + 64'(b)) % m);
                    power[k][str_len+1] = W_VAL'(((64'(power[k][str_len]) % m) * bb) % m);
                end
                str_len++;
            end
        end else if (act == ACT_QUERY) begin
            if (l == 0 || int'(r) > str_len || int'(l) > int'(r) + 1) begin
                e.status = ST_BAD;
            end else if (l <= r) begin
                e.hash_a = substring_hash(0, l, r);
                e.hash_b = substring_hash(1, l, r);
            end
        end else if (act == ACT_CLEAR) begin
            str_len = 0;
        end
        e.length = W_LEN'(str_len);
        pending.push_back(e);
    endfunction

    function void check_result(hash_beat_t got);
        hash_beat_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat status=%0d length=%0d", $time,
                     got.status, got.length);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.hash_a !== e.hash_a) begin
            $display("%0t: hash_a expected %0d actual %0d", $time, e.hash_a, got.hash_a);
            errors++;
        end
        if (got.hash_b !== e.hash_b) begin
            $display("%0t: hash_b expected %0d actual %0d", $time, e.hash_b, got.hash_b);
            errors++;
        end
        if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
        end
        if (got.length !== e.length) begin
            $display("%0t: length expected %0d actual %0d", $time, e.length, got.length);
            errors++;
        end
    endfunction
endclass

module dual_polynomial_substring_hash_top_tb;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [W_VAL-1:0] i_cfg_data;
    logic [1:0]       i_action;
    logic [7:0]       i_byte_in;
    logic [W_LEN-1:0] i_left;
    logic [W_LEN-1:0] i_right;
    logic             o_valid;
    logic [W_VAL-1:0] o_hash_a;
    logic [W_VAL-1:0] o_hash_b;
    logic [1:0]       o_status;
    logic [W_LEN-1:0] o_length;

    hash_scoreboard sb;
    bit             gaps_on;

    dual_polynomial_substring_hash_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_action   (i_action),
        .i_byte_in  (i_byte_in),
        .i_left     (i_left),
        .i_right    (i_right),
        .o_valid    (o_valid),
        .o_hash_a   (o_hash_a),
        .o_hash_b   (o_hash_b),
        .o_status   (o_status),
        .o_length   (o_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check every result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{o_hash_a, o_hash_b, o_status, o_length});
    end

    // Present one item, hold until accepted, then, when gaps are on, idle a random number of cycles
    task automatic send_item(logic [1:0] act, logic [7:0] b, logic [W_LEN-1:0] l,
                             logic [W_LEN-1:0] r);
        int gap;
        gap = gaps_on ? $urandom_range(0, 12) : 0;
        start     <= 1'b1;
        i_action  <= act;
        i_byte_in <= b;
        i_left    <= l;
        i_right   <= r;
        do @(posedge i_clk); while (busy);
        sb.note_item(act, b, l, r);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every expected beat has arrived
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [W_VAL-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [W_VAL-1:0] pick_mod();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return 31'd1;
            3: return 31'd2;
            4: return W_VAL'($urandom_range(3, 1000));
            default: return W_VAL'($urandom);
        endcase
    endfunction

    function automatic logic [W_VAL-1:0] pick_base();
        case ($urandom_range(0, 3))
            0: return 31'd1;
            1: return 31'h7FFF_FFFE;
            2: return 31'h7FFF_FFFF;
            default: return W_VAL'($urandom);
        endcase
    endfunction

    // One random item: mostly appends and in-range queries on a short string
    task automatic random_item();
        int len, r, l, sel;
        len = sb.str_len;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            if (len >= 48) send_item(ACT_CLEAR, 8'($urandom), 0, 0);
            else           send_item(ACT_APPEND, 8'($urandom), W_LEN'($urandom), 0);
        end else if (sel < 85) begin
            r = $urandom_range(0, len);
            l = $urandom_range(1, r + 1);
            send_item(ACT_QUERY, 8'($urandom), W_LEN'(l), W_LEN'(r));
        end else if (sel < 88) begin
            send_item(ACT_CLEAR, 8'($urandom), W_LEN'($urandom), W_LEN'($urandom));
        end else begin
            send_item(2'($urandom), 8'($urandom), W_LEN'($urandom), W_LEN'($urandom));
        end
    endtask

    initial begin
        sb         = new();
        gaps_on    = 1'b1;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_action   = ACT_APPEND;
        i_byte_in  = '0;
        i_left     = '0;
        i_right    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, bad ranges, unused action, extremes of bytes
        send_item(ACT_QUERY, 8'h00, 1, 0);
        send_item(ACT_QUERY, 8'h00, 0, 0);
        send_item(ACT_QUERY, 8'h00, 1, 1);
        send_item(ACT_UNUSED, 8'hFF, 13'h1FFF, 13'h1FFF);
        send_item(ACT_APPEND, 8'h00, 0, 0);
        send_item(ACT_APPEND, 8'hFF, 0, 0);
        send_item(ACT_APPEND, 8'h61, 0, 0);
        send_item(ACT_QUERY, 8'h00, 1, 3);
        send_item(ACT_QUERY, 8'h00, 2, 3);
        send_item(ACT_QUERY, 8'h00, 4, 3);
        send_item(ACT_QUERY, 8'h00, 3, 1);
        send_item(ACT_QUERY, 8'h00, 1, 4);
        send_item(ACT_CLEAR, 8'h00, 0, 0);
        send_item(ACT_QUERY, 8'h00, 1, 1);
        drain();

        // Directed: modulus zero and one, the largest base and a base above the modulus
        write_reg(REG_BASE_A, 31'h7FFF_FFFF);
        write_reg(REG_MOD_A, '0);
        write_reg(REG_BASE_B, 31'd5);
        write_reg(REG_MOD_B, 31'd1);
        send_item(ACT_APPEND, 8'hFF, 0, 0);
        send_item(ACT_APPEND, 8'h80, 0, 0);
        send_item(ACT_QUERY, 8'h00, 1, 2);
        drain();
        // Keep the stored tables across a register change
        write_reg(REG_MOD_A, 31'd7);
        write_reg(REG_MOD_B, 31'h7FFF_FFFF);
        send_item(ACT_APPEND, 8'h33, 0, 0);
        send_item(ACT_QUERY, 8'h00, 1, 3);
        send_item(ACT_QUERY, 8'h00, 2, 2);
        drain();

        // Build a longer string back to back, then the widest queries on it
        write_reg(REG_BASE_A, RST_BASE_A);
        write_reg(REG_MOD_A, RST_MOD_A);
        write_reg(REG_BASE_B, RST_BASE_B);
        write_reg(REG_MOD_B, RST_MOD_B);
        send_item(ACT_CLEAR, 8'h00, 0, 0);
        gaps_on = 1'b0;
        while (sb.str_len < 200)
            send_item(ACT_APPEND, 8'($urandom), 0, 0);
        gaps_on = 1'b1;
        send_item(ACT_QUERY, 8'h00, 1, 13'd200);
        send_item(ACT_QUERY, 8'h00, 13'd200, 13'd200);
        send_item(ACT_QUERY, 8'h00, 13'd201, 13'd200);
        send_item(ACT_QUERY, 8'h00, 1, 13'd201);
        send_item(ACT_QUERY, 8'h00, 13'd50, 13'd150);
        send_item(ACT_CLEAR, 8'h00, 0, 0);
        drain();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_BASE_A, pick_base());
            write_reg(REG_MOD_A, pick_mod());
            write_reg(REG_BASE_B, pick_base());
            write_reg(REG_MOD_B, pick_mod());
            gaps_on = (ph != 2);
            for (int n = 0; n < 140; n++) begin
                random_item();
                if (n == 70) drain();
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("dual_polynomial_substring_hash_top_tb passed");
        end else begin
            $display("dual_polynomial_substring_hash_top_tb failed");
        end
        $finish;
    end

    // Hold a hard limit on the run
    initial begin
        #20ms;
        $display("dual_polynomial_substring_hash_top_tb failed");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/dpsh_pkg.sv
hw/rtl/dpsh_mulmod.sv
hw/rtl/dual_polynomial_substring_hash_top.sv
sim/dual_polynomial_substring_hash_top_tb.sv
